// File: hdl/rsa_pkg.sv
// Shared types and codes for the refcounted slot allocator.
`timescale 1ns / 1ps
`default_nettype none
package rsa_pkg;
    localparam int KEY_W = 64;
    localparam int FENCE_W = 64;
    localparam int SLOT_OUT_W = 8;
    localparam int STATUS_W = 3;
    localparam int FREED_W = 9;
    localparam int COUNT_W = 16;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        FUNC_ADD     = 2'd0,
        FUNC_RELEASE = 2'd1,
        FUNC_RECYCLE = 2'd2,
        FUNC_NONE    = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_NEW      = 3'd0,
        ST_HIT      = 3'd1,
        ST_FULL     = 3'd2,
        ST_UNKNOWN  = 3'd3,
        ST_PEND_FULL = 3'd4
    } t_status;
endpackage
`default_nettype wire

// File: hdl/refcounted_slot_allocator_top.sv
// Top level of the refcounted slot allocator with its slot and pending memories.
// Usage: the input channel carries a request word (func, key, fence) under
// i_valid / o_stall; the output channel returns one result word (slot,
// status, freed_count) for every request under o_valid / i_stall.
// One request is worked on at a time. The key search reads the key memory
// for one slot in S_KSCAN and compares it in S_KCHK in the cycle after, so
// the slots are searched one after another until a hit or the table's end.
// An add miss then scans the occupancy bits one slot per cycle and takes the
// first free slot, or answers ST_FULL when the table is full. A release of an
// unknown key answers ST_UNKNOWN. A recycle walks the pending queue entry by
// entry through S_RCRD, S_RCCHK and S_RCWR, compacting entries in place. The
// unused selector answers with slot zero, status ST_NEW and no freed count.
// The result sits in an output register and o_stall stays high until that
// word has been taken, so the next request is accepted only after that.
// Reset clears the valid bits, the occupancy bits, the queue fill count,
// the state and the result valid flag; key, count and pending memories
// need no clearing. While the receiver stalls, the result word holds steady.
`timescale 1ns / 1ps
`default_nettype none
module refcounted_slot_allocator_top
    import rsa_pkg::*;
#(
    parameter int TABLE_SLOTS = 256,
    parameter int PENDING_DEPTH = 256
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [1:0]            i_func,
    input  wire logic [KEY_W-1:0]      i_key,
    input  wire logic [FENCE_W-1:0]    i_fence,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [SLOT_OUT_W-1:0]      o_slot,
    output logic [STATUS_W-1:0]        o_status,
    output logic [FREED_W-1:0]         o_freed_count
);
    localparam int SW = $clog2(TABLE_SLOTS);
    localparam int PW = $clog2(PENDING_DEPTH);
    localparam int UW = $clog2(PENDING_DEPTH + 1);

    typedef enum logic [9:0] {
        S_IDLE    = 10'b0000000001,
        S_KSCAN   = 10'b0000000010,
        S_KCHK    = 10'b0000000100,
        S_FSCAN   = 10'b0000001000,
        S_UPD     = 10'b0000010000,
        S_RCRD    = 10'b0000100000,
        S_RCCHK   = 10'b0001000000,
        S_RCWR    = 10'b0010000000,
        S_DONE    = 10'b0100000000,
        S_OUT     = 10'b1000000000
    } t_state;

    logic [KEY_W-1:0]   m_key [TABLE_SLOTS];
    logic [COUNT_W-1:0] m_cnt [TABLE_SLOTS];
    logic [SW-1:0]      m_pslot [PENDING_DEPTH];
    logic [FENCE_W-1:0] m_pfence [PENDING_DEPTH];

    logic [TABLE_SLOTS-1:0] r_valid_bits, r_occ;
    t_state             r_state;
    logic [1:0]         r_func;
    logic [KEY_W-1:0]   r_key;
    logic [FENCE_W-1:0] r_fence;
    logic [SW:0]        r_idx;
    logic [SW-1:0]      r_hit_slot;
    logic               r_hit;
    logic [UW-1:0]      r_used, r_rd, r_wr;
    logic [FREED_W-1:0] r_freed;
    logic [KEY_W-1:0]   r_kq;
    logic [COUNT_W-1:0] r_cq;
    logic [SW-1:0]      r_psq;
    logic [FENCE_W-1:0] r_pfq;
    logic               r_out_valid;
    logic [SLOT_OUT_W-1:0] r_slot;
    logic [STATUS_W-1:0]   r_status;
    logic [FREED_W-1:0]    r_fc;
    logic [SW-1:0]      r_last_idx;

    logic              mk_we, mc_we, mp_we;
    logic [SW-1:0]     mk_addr, mc_addr;
    logic [COUNT_W-1:0] mc_wd;
    logic [PW-1:0]     mp_raddr, mp_waddr;
    logic [SW-1:0]     mp_wslot;
    logic [FENCE_W-1:0] mp_wfence;

    assign o_stall = (r_state != S_IDLE) || r_out_valid;
    assign o_valid = r_out_valid;
    assign o_slot = r_slot;
    assign o_status = r_status;
    assign o_freed_count = r_fc;

    always_ff @(posedge i_clk) begin
        if (mk_we) m_key[mk_addr] <= r_key;
        r_kq <= m_key[mk_addr];
    end
    always_ff @(posedge i_clk) begin
        if (mc_we) m_cnt[mc_addr] <= mc_wd;
        r_cq <= m_cnt[mc_addr];
    end
    always_ff @(posedge i_clk) begin
        if (mp_we) begin
            m_pslot[mp_waddr] <= mp_wslot;
            m_pfence[mp_waddr] <= mp_wfence;
        end
        r_psq <= m_pslot[mp_raddr];
        r_pfq <= m_pfence[mp_raddr];
    end

    // Memory port control.
    always_comb begin
        mk_we = 1'b0;
        mc_we = 1'b0;
        mp_we = 1'b0;
        mk_addr = r_idx[SW-1:0];
        mc_addr = r_idx[SW-1:0];
        mc_wd = r_cq;
        mp_raddr = r_rd[PW-1:0];
        mp_waddr = r_wr[PW-1:0];
        mp_wslot = r_psq;
        mp_wfence = r_pfq;
        unique case (r_state)
            S_KCHK: begin
                mc_addr = r_last_idx;
            end
            S_UPD: begin
                mk_addr = r_hit_slot;
                mc_addr = r_hit_slot;
                mp_waddr = r_used[PW-1:0];
                mp_wslot = r_hit_slot;
                mp_wfence = r_fence;
                if (r_func == FUNC_ADD) begin
                    if (r_hit) begin
                        mc_we = 1'b1;
                        mc_wd = (r_cq == COUNT_MAX) ? r_cq : r_cq + 1'b1;
                    end else begin
                        mk_we = 1'b1;
                        mc_we = 1'b1;
                        mc_wd = COUNT_W'(1);
                    end
                end else if (r_cq > COUNT_W'(1)) begin
                    mc_we = 1'b1;
                    mc_wd = r_cq - 1'b1;
                end else if (r_used < UW'(PENDING_DEPTH)) begin
                    mc_we = 1'b1;
                    mc_wd = '0;
                    mp_we = 1'b1;
                end
            end
            S_RCWR: begin
                mp_we = (r_pfq > r_fence);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid_bits <= '0;
            r_occ <= '0;
            r_used <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && !o_stall) begin
                        r_func <= i_func;
                        r_key <= i_key;
                        r_fence <= i_fence;
                        r_idx <= '0;
                        r_hit <= 1'b0;
                        r_rd <= '0;
                        r_wr <= '0;
                        r_freed <= '0;
                        unique case (t_func'(i_func))
                            FUNC_ADD, FUNC_RELEASE: r_state <= S_KSCAN;
                            FUNC_RECYCLE: r_state <= S_RCRD;
                            default: begin
                                r_slot <= '0;
                                r_status <= ST_NEW;
                                r_fc <= '0;
                                r_state <= S_OUT;
                            end
                        endcase
                    end
                end
                S_KSCAN: begin
                    // Read issued for r_idx; compare next cycle.
                    r_last_idx <= r_idx[SW-1:0];
                    r_idx <= r_idx + 1'b1;
                    r_state <= S_KCHK;
                end
                S_KCHK: begin
                    if (r_valid_bits[r_last_idx] && r_kq == r_key) begin
                        r_hit <= 1'b1;
                        r_hit_slot <= r_last_idx;
                        r_state <= S_UPD;
                    end else if (r_idx == (SW+1)'(TABLE_SLOTS)) begin
                        if (r_func == FUNC_ADD) begin
                            r_idx <= '0;
                            r_state <= S_FSCAN;
                        end else begin
                            r_slot <= '0;
                            r_status <= ST_UNKNOWN;
                            r_fc <= '0;
                            r_state <= S_OUT;
                        end
                    end else begin
                        r_state <= S_KSCAN;
                    end
                end
                S_FSCAN: begin
                    if (!r_occ[r_idx[SW-1:0]]) begin
                        r_hit_slot <= r_idx[SW-1:0];
                        r_state <= S_UPD;
                    end else if (r_idx == (SW+1)'(TABLE_SLOTS - 1)) begin
                        r_slot <= '0;
                        r_status <= ST_FULL;
                        r_fc <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_UPD: begin
                    r_slot <= SLOT_OUT_W'(r_hit_slot);
                    r_fc <= '0;
                    r_status <= ST_HIT;
                    if (r_func == FUNC_ADD) begin
                        if (!r_hit) begin
                            r_occ[r_hit_slot] <= 1'b1;
                            r_valid_bits[r_hit_slot] <= 1'b1;
                            r_status <= ST_NEW;
                        end
                    end else if (r_cq <= COUNT_W'(1)) begin
                        if (r_used < UW'(PENDING_DEPTH)) begin
                            r_valid_bits[r_hit_slot] <= 1'b0;
                            r_used <= r_used + 1'b1;
                        end else begin
                            r_status <= ST_PEND_FULL;
                        end
                    end
                    r_state <= S_OUT;
                end
                S_RCRD: begin
                    if (r_rd == r_used) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_RCCHK;
                    end
                end
                S_RCCHK: begin
                    r_state <= S_RCWR;
                end
                S_RCWR: begin
                    if (r_pfq <= r_fence) begin
                        r_occ[r_psq] <= 1'b0;
                        r_freed <= r_freed + 1'b1;
                    end else begin
                        r_wr <= r_wr + 1'b1;
                    end
                    r_rd <= r_rd + 1'b1;
                    r_state <= S_RCRD;
                end
                S_DONE: begin
                    r_used <= r_wr;
                    r_slot <= '0;
                    r_status <= ST_NEW;
                    r_fc <= r_freed;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid || !i_stall) begin
                        r_out_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= UW'(PENDING_DEPTH))
        else $error("pending count above depth");
    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall)
        else $error("ready while busy");
    a_valid_implies_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_valid_bits & ~r_occ) == '0))
        else $error("valid key on free slot");
    a_out_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_OUT))
        else $error("result raised outside output state");
endmodule
`default_nettype wire

// File: verif/refcounted_slot_allocator_top_tb.sv
// Self-checking testbench for the refcounted slot allocator: add, release, recycle and idle words.
`timescale 1ns / 1ps
module refcounted_slot_allocator_top_tb;
    import rsa_pkg::*;

    localparam int SLOTS = 256;
    localparam int PEND = 256;
    localparam int CYCLE_LIMIT = 4000000;

    typedef struct packed {
        logic [7:0] slot;
        logic [2:0] status;
        logic [8:0] freed;
    } t_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic [1:0] i_func = FUNC_NONE;
    logic [63:0] i_key = '0;
    logic [63:0] i_fence = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic [7:0] o_slot;
    logic [2:0] o_status;
    logic [8:0] o_freed_count;

    refcounted_slot_allocator_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_func(i_func), .i_key(i_key), .i_fence(i_fence), .o_valid(o_valid),
        .i_stall(i_stall), .o_slot(o_slot), .o_status(o_status),
        .o_freed_count(o_freed_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow state of the allocator.
    logic        in_use [SLOTS];
    logic [63:0] slot_key [SLOTS];
    logic        key_live [SLOTS];
    logic [15:0] refs [SLOTS];
    logic [7:0]  queued_slot [PEND];
    logic [63:0] queued_fence [PEND];
    int          queued_n;

    t_result expected_results[$];
    logic [63:0] key_pool[$];
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatches = 0;
    int words_sent = 0;
    int results_seen = 0;
    int hits = 0, fulls = 0, pend_fulls = 0, unknowns = 0;
    longint cycles = 0;

    function automatic int lookup_key(logic [63:0] k);
        for (int s = 0; s < SLOTS; s++)
            if (key_live[s] && slot_key[s] == k) return s;
        return -1;
    endfunction

    function automatic t_result allocate_step(logic [1:0] f, logic [63:0] k, logic [63:0] fe);
        t_result r;
        int s;
        int w;
        int freed;
        r = '0;
        case (f)
            FUNC_ADD: begin
                s = lookup_key(k);
                if (s >= 0) begin
                    if (refs[s] != COUNT_MAX) refs[s]++;
                    r.slot = s[7:0];
                    r.status = ST_HIT;
                end else begin
                    s = -1;
                    for (int i = 0; i < SLOTS && s < 0; i++)
                        if (!in_use[i]) s = i;
                    if (s < 0) begin
                        r.status = ST_FULL;
                    end else begin
                        in_use[s] = 1'b1;
                        slot_key[s] = k;
                        key_live[s] = 1'b1;
                        refs[s] = 16'd1;
                        r.slot = s[7:0];
                        r.status = ST_NEW;
                    end
                end
            end
            FUNC_RELEASE: begin
                s = lookup_key(k);
                if (s < 0) begin
                    r.status = ST_UNKNOWN;
                end else begin
                    r.slot = s[7:0];
                    r.status = ST_HIT;
                    if (refs[s] > 1) begin
                        refs[s]--;
                    end else if (queued_n >= PEND) begin
                        r.status = ST_PEND_FULL;
                    end else begin
                        refs[s] = '0;
                        key_live[s] = 1'b0;
                        queued_slot[queued_n] = s[7:0];
                        queued_fence[queued_n] = fe;
                        queued_n++;
                    end
                end
            end
            FUNC_RECYCLE: begin
                w = 0;
                freed = 0;
                for (int i = 0; i < queued_n; i++) begin
                    if (queued_fence[i] <= fe) begin
                        in_use[queued_slot[i]] = 1'b0;
                        freed++;
                    end else begin
                        queued_slot[w] = queued_slot[i];
                        queued_fence[w] = queued_fence[i];
                        w++;
                    end
                end
                queued_n = w;
                r.freed = freed[8:0];
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_word(logic [1:0] f, logic [63:0] k, logic [63:0] fe);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        expected_results.push_back(allocate_step(f, k, fe));
        i_valid <= 1'b1;
        i_func <= f;
        i_key <= k;
        i_fence <= fe;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        words_sent++;
    endtask

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[refcounted_slot_allocator_top] ERROR");
            $finish;
        end
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected result word: slot %0d status %0d freed %0d",
                                 o_slot, o_status, o_freed_count);
                end else begin
                    t_result e;
                    e = expected_results.pop_front();
                    if (e.status == ST_HIT || e.status == ST_PEND_FULL) hits++;
                    if (e.status == ST_FULL) fulls++;
                    if (e.status == ST_PEND_FULL) pend_fulls++;
                    if (e.status == ST_UNKNOWN) unknowns++;
                    if (o_slot !== e.slot || o_status !== e.status
                            || o_freed_count !== e.freed) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"Mismatch: expected slot %0d status %0d freed %0d, ",
                                      "got slot %0d status %0d freed %0d"},
                                     e.slot, e.status, e.freed, o_slot, o_status,
                                     o_freed_count);
                    end
                end
            end
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic drain;
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] pick_key();
        if (key_pool.size() == 0 || $urandom_range(9) == 0) begin
            key_pool.push_back(rand64());
            return key_pool[key_pool.size()-1];
        end
        return key_pool[$urandom_range(key_pool.size()-1)];
    endfunction

    task automatic test_directed;
        send_word(FUNC_RELEASE, 64'd5, 64'd0);
        send_word(FUNC_ADD, 64'd0, 64'd0);
        send_word(FUNC_ADD, '1, '1);
        send_word(FUNC_ADD, '1, 64'd0);
        send_word(FUNC_RELEASE, '1, 64'd7);
        send_word(FUNC_RELEASE, '1, '1);
        send_word(FUNC_RELEASE, 64'd0, 64'd3);
        send_word(FUNC_RECYCLE, '0, 64'd2);
        send_word(FUNC_RECYCLE, '0, 64'd3);
        send_word(FUNC_NONE, '1, '1);
        send_word(FUNC_RECYCLE, '1, '1);
        send_word(FUNC_ADD, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        send_word(FUNC_RELEASE, 64'h5555_5555_5555_5555, 64'h8000_0000_0000_0000);
        send_word(FUNC_RECYCLE, '0, 64'h7FFF_FFFF_FFFF_FFFF);
        send_word(FUNC_RECYCLE, '0, 64'h8000_0000_0000_0000);
        drain();
    endtask

    // Fills the table, checks the full case, then queues every slot and frees them.
    task automatic test_full_table;
        for (int i = 0; i < SLOTS; i++) send_word(FUNC_ADD, 64'h1000 + i, '0);
        send_word(FUNC_ADD, 64'hDEAD, '0);
        for (int i = 0; i < SLOTS; i++) send_word(FUNC_RELEASE, 64'h1000 + i, 64'(i));
        send_word(FUNC_RECYCLE, '0, 64'd99);
        send_word(FUNC_RECYCLE, '0, '1);
        drain();
    endtask

    task automatic test_random(int n);
        int sel;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(99);
            if (sel < 50) send_word(FUNC_ADD, pick_key(), rand64());
            else if (sel < 85) send_word(FUNC_RELEASE, pick_key(), 64'($urandom_range(200)));
            else if (sel < 95) send_word(FUNC_RECYCLE, rand64(), 64'($urandom_range(220)));
            else if (sel < 98) send_word(FUNC_RELEASE, rand64(), rand64());
            else send_word(FUNC_NONE, rand64(), rand64());
        end
    endtask

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            in_use[i] = 1'b0;
            key_live[i] = 1'b0;
            refs[i] = '0;
            slot_key[i] = '0;
        end
        queued_n = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_full_table();
        send_idle_pct = 0; recv_stall_pct = 0;
        test_random(170);
        send_idle_pct = 60; recv_stall_pct = 0;
        test_random(170);
        drain();
        send_idle_pct = 0; recv_stall_pct = 60;
        test_random(170);
        send_idle_pct = 20; recv_stall_pct = 20;
        test_random(170);
        drain();
        repeat (600) @(posedge i_clk);
        $display("Sent %0d words and checked %0d results under idle and stall phases.",
                 words_sent, results_seen);
        $display("Seen: %0d hits, %0d table full, %0d pending full, %0d unknown keys.",
                 hits, fulls, pend_fulls, unknowns);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("[refcounted_slot_allocator_top] OK");
        else
            $display("[refcounted_slot_allocator_top] ERROR");
        $finish;
    end
endmodule

// File: refcounted_slot_allocator_top.f
hdl/rsa_pkg.sv
hdl/refcounted_slot_allocator_top.sv
verif/refcounted_slot_allocator_top_tb.sv
